// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define TBD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// property that must never hold outside reset
`define TBD_ASSERT_NEVER(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error(msg);

`endif

// File: hw/rtl/tbd_pkg.sv
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared types and constants for the tracked block drive command block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbd_pkg;

   // packet format
   localparam int MAX_PACKET_DEF = 256;
   localparam int POS_LEN        = 3;
   localparam int POS_SUM_LO     = 4;
   localparam int POS_SUM_HI     = 5;
   localparam int POS_PAYLOAD    = 6;
   localparam int LEN_W          = 9;

   // motor frame
   localparam logic [7:0] FRAME_HEADER = 8'h7A;
   localparam logic [7:0] FRAME_KEY    = 8'h7F;
   localparam logic [1:0] FRAME_LAST   = 2'd3;
   localparam int         FRAME_BYTES  = 4;

   // direction codes
   localparam logic [3:0] DIR_FWD         = 4'd1;
   localparam logic [3:0] DIR_REV         = 4'd2;
   localparam logic [3:0] DIR_LEFT_FAR    = 4'd3;
   localparam logic [3:0] DIR_RIGHT_NEAR  = 4'd4;
   localparam logic [3:0] DIR_RIGHT_FAR   = 4'd5;
   localparam logic [3:0] DIR_LEFT_NEAR   = 4'd6;
   localparam logic [3:0] DIR_RIGHT_MID   = 4'd7;
   localparam logic [3:0] DIR_LEFT_MID    = 4'd8;
   localparam logic [3:0] DIR_STOP        = 4'd9;

   // register widths and reset values
   localparam int EDGE_W  = 10;
   localparam int AREA_CW = 20;
   localparam int SPEED_W = 7;
   localparam int CSR_W   = 20;
   localparam int CSR_IDX_W = 3;

   localparam logic [EDGE_W-1:0]  X_LEFT_RST    = 10'd138;
   localparam logic [EDGE_W-1:0]  X_RIGHT_RST   = 10'd178;
   localparam logic [EDGE_W-1:0]  Y_LOW_RST     = 10'd89;
   localparam logic [EDGE_W-1:0]  Y_HIGH_RST    = 10'd119;
   localparam logic [AREA_CW-1:0] CLOSE_RST     = 20'd6000;
   localparam logic [AREA_CW-1:0] STOP_RST      = 20'd30000;
   localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 7'd40;

   localparam logic [AREA_CW-1:0] REV_RATIO = 20'd25000;

   // divider sizing: speed scale times a 20-bit area
   localparam int NUM_W = SPEED_W + AREA_CW;
   localparam int DEN_W = AREA_CW;
   localparam int CNT_W = $clog2(NUM_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_LEFT    = 3'd0,
      CSR_X_RIGHT   = 3'd1,
      CSR_Y_LOW     = 3'd2,
      CSR_Y_HIGH    = 3'd3,
      CSR_CLOSE     = 3'd4,
      CSR_STOP      = 3'd5,
      CSR_MAX_SPEED = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCALE,
      ST_DIVIDE,
      ST_LOAD,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic accept;
      logic check;
      logic scale;
      logic div_step;
      logic load;
      logic shift;
   } cmd_type;

   typedef struct packed {
      logic closes;
      logic sum_ok;
      logic sum_zero;
      logic div_needed;
      logic div_done;
   } status_type;

endpackage

// File: hw/rtl/tbd_ctrl.sv
// ----------------------------------------------------------------------------
// tbd_ctrl
// Sequencer: packet intake, checksum test, speed division and frame send.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbd_ctrl import tbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_last,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] sent_ff, sent_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sent_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sent_ff  <= sent_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sent_in   = sent_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_last  = sent_ff == FRAME_LAST;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && status.closes) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (!status.sum_ok) begin
               state_in = ST_IDLE;
            end else if (status.sum_zero) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = status.div_needed ? ST_DIVIDE : ST_LOAD;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            sent_in  = '0;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            cmd.shift = rsp_ready;
            if (rsp_ready) begin
               sent_in = sent_ff + 2'd1;
               if (sent_ff == FRAME_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/tbd_dp.sv
// ----------------------------------------------------------------------------
// tbd_dp
// Datapath: packet parser, settings, area multiply, speed divider, frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbd_dp import tbd_pkg::*; #(
   parameter int MAX_PACKET = MAX_PACKET_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_rx_byte,
   input  logic                 req_first,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  cmd_type              cmd,
   output status_type           status,
   output logic [7:0]           rsp_cmd_byte
);

   localparam int POS_W = $clog2(MAX_PACKET);
   localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

   // settings
   logic [EDGE_W-1:0]  x_left_ff, x_right_ff, y_low_ff, y_high_ff;
   logic [AREA_CW-1:0] close_ff, stop_ff;
   logic [SPEED_W-1:0] max_speed_ff;

   // packet state
   logic [POS_W-1:0] byte_pos_ff, byte_pos_in;
   logic             active_ff, active_in;
   logic [7:0]       payload_len_ff, payload_len_in;
   logic [15:0]      rx_sum_ff, rx_sum_in;
   logic [15:0]      payload_sum_ff, payload_sum_in;
   logic [15:0]      blk_ff [4];
   logic [15:0]      blk_in [4];

   // decision and divider
   logic [31:0]      area_ff;
   logic [3:0]       dir_ff;
   logic [7:0]       spd_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] div_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [7:0]       frame_ff [FRAME_BYTES];

   // ---------------------------------------------------------------- parser
   logic [POS_W-1:0] pos_cur;
   logic             act_cur;
   logic [CMP_W-1:0] pos_ext, end_ext;
   logic             in_payload, is_end;

   always_comb begin
      pos_cur        = req_first ? '0 : byte_pos_ff;
      act_cur        = req_first | active_ff;
      payload_len_in = req_first ? '0 : payload_len_ff;
      rx_sum_in      = req_first ? '0 : rx_sum_ff;
      payload_sum_in = req_first ? '0 : payload_sum_ff;
      for (int i = 0; i < 4; i++) begin
         blk_in[i] = req_first ? '0 : blk_ff[i];
      end
      byte_pos_in = pos_cur;
      active_in   = act_cur;

      pos_ext    = CMP_W'(pos_cur);
      end_ext    = CMP_W'(LEN_W'(payload_len_in) + LEN_W'(POS_SUM_HI));
      in_payload = (pos_ext >= CMP_W'(POS_PAYLOAD)) && (pos_ext <= end_ext);
      is_end     = pos_ext == end_ext;

      if (pos_ext == CMP_W'(POS_LEN)) begin
         payload_len_in = req_rx_byte;
      end else if (pos_ext == CMP_W'(POS_SUM_LO)) begin
         rx_sum_in[7:0] = req_rx_byte;
      end else if (pos_ext == CMP_W'(POS_SUM_HI)) begin
         rx_sum_in[15:8] = req_rx_byte;
      end

      if (in_payload) begin
         payload_sum_in = payload_sum_in + 16'(req_rx_byte);
         // positions 8 to 15 carry x, y, width, height, low byte first
         if (pos_ext[CMP_W-1:4] == '0 && pos_ext[3]) begin
            if (pos_ext[0]) begin
               blk_in[pos_ext[2:1]][15:8] = req_rx_byte;
            end else begin
               blk_in[pos_ext[2:1]][7:0] = req_rx_byte;
            end
         end
      end

      if (is_end) begin
         active_in = 1'b0;
      end else if (pos_cur >= POS_W'(MAX_PACKET - 1)) begin
         active_in = 1'b0;
      end else begin
         byte_pos_in = pos_cur + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff    <= '0;
         active_ff      <= 1'b0;
         payload_len_ff <= '0;
         rx_sum_ff      <= '0;
         payload_sum_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            blk_ff[i] <= '0;
         end
      end else if (cmd.accept && act_cur) begin
         byte_pos_ff    <= byte_pos_in;
         active_ff      <= active_in;
         payload_len_ff <= payload_len_in;
         rx_sum_ff      <= rx_sum_in;
         payload_sum_ff <= payload_sum_in;
         for (int i = 0; i < 4; i++) begin
            blk_ff[i] <= blk_in[i];
         end
      end
   end

   // -------------------------------------------------------------- settings
   always_ff @(posedge clock) begin
      if (reset) begin
         x_left_ff    <= X_LEFT_RST;
         x_right_ff   <= X_RIGHT_RST;
         y_low_ff     <= Y_LOW_RST;
         y_high_ff    <= Y_HIGH_RST;
         close_ff     <= CLOSE_RST;
         stop_ff      <= STOP_RST;
         max_speed_ff <= MAX_SPEED_RST;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_X_LEFT:    x_left_ff    <= csr_wdata[EDGE_W-1:0];
            CSR_X_RIGHT:   x_right_ff   <= csr_wdata[EDGE_W-1:0];
            CSR_Y_LOW:     y_low_ff     <= csr_wdata[EDGE_W-1:0];
            CSR_Y_HIGH:    y_high_ff    <= csr_wdata[EDGE_W-1:0];
            CSR_CLOSE:     close_ff     <= csr_wdata[AREA_CW-1:0];
            CSR_STOP:      stop_ff      <= csr_wdata[AREA_CW-1:0];
            CSR_MAX_SPEED: max_speed_ff <= csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------- decision
   logic             too_close, over_stop, ymid, xmid, xright;
   logic [3:0]       dir_calc;
   logic [AREA_CW-1:0] num_operand;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W+1:0] rem_diff;
   logic             q_bit;
   logic [NUM_W-1:0] quot;

   always_comb begin
      too_close = area_ff > 32'(close_ff);
      over_stop = area_ff > 32'(stop_ff);
      ymid      = (blk_ff[1] > 16'(y_low_ff)) && (blk_ff[1] < 16'(y_high_ff));
      xmid      = (blk_ff[0] < 16'(x_right_ff)) && (blk_ff[0] > 16'(x_left_ff));
      xright    = blk_ff[0] >= 16'(x_right_ff);
      priority if (xmid) begin
         dir_calc = too_close ? DIR_REV : DIR_FWD;
      end else if (xright) begin
         dir_calc = too_close ? DIR_RIGHT_NEAR : (ymid ? DIR_RIGHT_MID : DIR_RIGHT_FAR);
      end else begin
         dir_calc = too_close ? DIR_LEFT_NEAR : (ymid ? DIR_LEFT_MID : DIR_LEFT_FAR);
      end
      // area stays within 20 bits on every path that divides
      num_operand = too_close ? area_ff[AREA_CW-1:0] : (close_ff - area_ff[AREA_CW-1:0]);

      status.div_needed = too_close ? !over_stop : (close_ff != '0);
      status.div_done   = cnt_ff == CNT_W'(NUM_W - 1);
      status.sum_ok     = payload_sum_ff == rx_sum_ff;
      status.sum_zero   = payload_sum_ff == '0;
      status.closes     = act_cur && is_end;

      // restoring division, one quotient bit per cycle
      rem_shift = {rem_ff, num_ff[NUM_W-1]};
      rem_diff  = {1'b0, rem_shift} - {2'b00, div_ff};
      q_bit     = !rem_diff[DEN_W+1];
      quot      = {num_ff[NUM_W-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         area_ff <= 32'(blk_ff[2]) * 32'(blk_ff[3]);
         dir_ff  <= DIR_STOP;
         spd_ff  <= '0;
      end
      if (cmd.scale) begin
         dir_ff <= dir_calc;
         num_ff <= NUM_W'(max_speed_ff) * NUM_W'(num_operand);
         div_ff <= too_close ? REV_RATIO : close_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
         if (too_close) begin
            spd_ff <= '0;
         end else begin
            spd_ff <= 8'(max_speed_ff);
         end
      end
      if (cmd.div_step) begin
         num_ff <= quot;
         rem_ff <= q_bit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (status.div_done) begin
            spd_ff <= (quot[NUM_W-1:8] != '0) ? 8'hFF : quot[7:0];
         end
      end
      if (cmd.load) begin
         frame_ff[0] <= FRAME_HEADER;
         frame_ff[1] <= 8'(dir_ff);
         frame_ff[2] <= spd_ff;
         frame_ff[3] <= 8'(dir_ff) ^ spd_ff ^ FRAME_KEY;
      end else if (cmd.shift) begin
         for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            frame_ff[i] <= frame_ff[i+1];
         end
      end
   end

   assign rsp_cmd_byte = frame_ff[0];

endmodule

// File: hw/rtl/tracked_block_drive_command.sv
// Reply bytes are taken one byte per cycle while the block is idle. A packet end
// runs the checksum test; a good sum goes on to the speed scale, the bit-serial
// speed divide when it is needed, the frame load and the send, a zero sum goes
// straight to the load, a bad sum frees the input. Frame bytes go one per handshake.
// Synchronous active-high reset returns all settings to their defaults and
// closes any open packet.
// ----------------------------------------------------------------------------
// tracked_block_drive_command
// Turns camera block-report replies into four-byte motor frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tracked_block_drive_command import tbd_pkg::*; #(
   parameter int MAX_PACKET = MAX_PACKET_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 req_first,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_cmd_byte,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_last  (rsp_last),
      .status    (status),
      .cmd       (cmd)
   );

   tbd_dp #(
      .MAX_PACKET (MAX_PACKET)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_rx_byte  (req_rx_byte),
      .req_first    (req_first),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_cmd_byte (rsp_cmd_byte)
   );

endmodule

// File: hw/rtl/tbd_checker.sv
// ----------------------------------------------------------------------------
// tbd_checker
// Port-level checks on frame sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbd_checker import tbd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_cmd_byte,
   input logic       rsp_last
);

   // a frame goes out without gaps once started
   `TBD_ASSERT(a_frame_unbroken, clock, reset, rsp_valid && rsp_ready && !rsp_last |=> rsp_valid, "frame interrupted")
   // no intake while a frame is being sent
   `TBD_ASSERT_NEVER(a_no_overlap, clock, reset, req_ready && rsp_valid, "item taken during frame")
   // every frame opens with the header byte
   `TBD_ASSERT(a_header_first, clock, reset, $rose(rsp_valid) |-> rsp_cmd_byte == FRAME_HEADER && !rsp_last, "bad frame start")
   // stalled output holds
   `TBD_ASSERT(a_hold_stall, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cmd_byte) && $stable(rsp_last), "stalled item changed")

endmodule

bind tracked_block_drive_command tbd_checker u_tbd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_cmd_byte (rsp_cmd_byte),
   .rsp_last     (rsp_last)
);

// File: tb/sv/tb_tracked_block_drive_command.sv
// ----------------------------------------------------------------------------
// tb_tracked_block_drive_command
// Streams camera block-report bytes into the drive command block, good
// packets with random content mixed with bad sums, cut packets and stray
// bytes, under several threshold settings, and checks every motor frame
// byte against an in-bench model of the decision and speed arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tracked_block_drive_command;
   import tbd_pkg::*;

   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 40;
   localparam int END_WAIT        = 5000;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASE_ITEMS     = 16;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       first;
   } reply_byte_type;

   typedef struct packed {
      logic [7:0] cmd_byte;
      logic       last;
   } frame_byte_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'd0;
   logic req_first = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_cmd_byte;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   reply_byte_type reply_bytes_to_send[$];
   frame_byte_type frame_bytes_due[$];

   // thresholds as the block should hold them
   logic [EDGE_W-1:0]  x_left = X_LEFT_RST;
   logic [EDGE_W-1:0]  x_right = X_RIGHT_RST;
   logic [EDGE_W-1:0]  y_low = Y_LOW_RST;
   logic [EDGE_W-1:0]  y_high = Y_HIGH_RST;
   logic [AREA_CW-1:0] close_lim = CLOSE_RST;
   logic [AREA_CW-1:0] stop_lim = STOP_RST;
   logic [SPEED_W-1:0] top_speed = MAX_SPEED_RST;

   // packet parser state
   logic [8:0]  pos_cnt = '0;
   logic        pkt_open = 1'b0;
   logic [7:0]  len_byte = '0;
   logic [15:0] sum_field = '0;
   logic [15:0] run_sum = '0;
   logic [15:0] blk_x = '0;
   logic [15:0] blk_y = '0;
   logic [15:0] blk_w = '0;
   logic [15:0] blk_h = '0;

   int mismatches = 0;
   int frames_seen = 0;
   int queued_items = 0;
   int taken_items = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;

   tracked_block_drive_command DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .req_first    (req_first),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_cmd_byte (rsp_cmd_byte),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   function automatic logic [3:0] steer_direction(input logic [31:0] area);
      logic near;
      logic ymid;
      near = area <= close_lim;
      ymid = blk_y > y_low && blk_y < y_high;
      // middle section wins, then right, then left
      if (blk_x < x_right && blk_x > x_left)
         return near ? DIR_FWD : DIR_REV;
      if (blk_x >= x_right)
         return near ? (ymid ? DIR_RIGHT_MID : DIR_RIGHT_FAR) : DIR_RIGHT_NEAR;
      return near ? (ymid ? DIR_LEFT_MID : DIR_LEFT_FAR) : DIR_LEFT_NEAR;
   endfunction

   function automatic logic [7:0] drive_speed(input logic [31:0] area);
      logic [63:0] v;
      if (area > close_lim) begin
         if (area > stop_lim)
            return 8'd0;
         v = 64'(top_speed) * area / REV_RATIO;
      end else if (close_lim == 0) begin
         v = 64'(top_speed);
      end else begin
         v = 64'(top_speed) * (close_lim - area) / close_lim;
      end
      return (v > 64'd255) ? 8'd255 : v[7:0];
   endfunction

   task automatic take_reply_byte(input logic [7:0] b, input logic first);
      logic [8:0]  pos;
      logic [7:0]  dir_code;
      logic [7:0]  speed;
      logic [31:0] area;
      if (first) begin
         pos_cnt = '0;
         len_byte = '0;
         sum_field = '0;
         run_sum = '0;
         blk_x = '0;
         blk_y = '0;
         blk_w = '0;
         blk_h = '0;
         pkt_open = 1'b1;
      end
      if (!pkt_open)
         return;
      pos = pos_cnt;
      if (pos == POS_LEN)
         len_byte = b;
      else if (pos == POS_SUM_LO)
         sum_field[7:0] = b;
      else if (pos == POS_SUM_HI)
         sum_field[15:8] = b;
      if (pos >= POS_PAYLOAD && pos < POS_PAYLOAD + len_byte) begin
         run_sum = run_sum + b;
         case (pos)
            POS_PAYLOAD + 2: blk_x[7:0] = b;
            POS_PAYLOAD + 3: blk_x[15:8] = b;
            POS_PAYLOAD + 4: blk_y[7:0] = b;
            POS_PAYLOAD + 5: blk_y[15:8] = b;
            POS_PAYLOAD + 6: blk_w[7:0] = b;
            POS_PAYLOAD + 7: blk_w[15:8] = b;
            POS_PAYLOAD + 8: blk_h[7:0] = b;
            POS_PAYLOAD + 9: blk_h[15:8] = b;
            default: ;
         endcase
      end
      if (pos < POS_SUM_HI || pos != POS_SUM_HI + len_byte) begin
         // overlong packets are dropped silently
         if (pos >= MAX_PACKET_DEF - 1)
            pkt_open = 1'b0;
         else
            pos_cnt = pos + 9'd1;
         return;
      end
      pkt_open = 1'b0;
      if (run_sum != sum_field)
         return;
      if (run_sum == 0) begin
         dir_code = {4'd0, DIR_STOP};
         speed = 8'd0;
      end else begin
         area = blk_w * blk_h;
         dir_code = {4'd0, steer_direction(area)};
         speed = drive_speed(area);
      end
      frame_bytes_due.push_back({FRAME_HEADER, 1'b0});
      frame_bytes_due.push_back({dir_code, 1'b0});
      frame_bytes_due.push_back({speed, 1'b0});
      frame_bytes_due.push_back({dir_code ^ speed ^ FRAME_KEY, 1'b1});
   endtask

   always @(posedge clock) begin : driver
      reply_byte_type item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            take_reply_byte(req_rx_byte, req_first);
            taken_items++;
         end
         if (req_valid && !req_ready) begin
            // hold the item until it is taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (reply_bytes_to_send.size() > 0 && idle_on && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(0, 9);
            req_valid <= 1'b0;
         end else if (reply_bytes_to_send.size() > 0) begin
            item = reply_bytes_to_send.pop_front();
            req_rx_byte <= item.rx_byte;
            req_first <= item.first;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      frame_byte_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               report_mismatch($sformatf("frame byte %0d: %02h with none expected",
                                         frames_seen, rsp_cmd_byte));
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_cmd_byte !== want.cmd_byte)
                  report_mismatch($sformatf("frame byte %0d: cmd_byte %02h, want %02h",
                                            frames_seen, rsp_cmd_byte, want.cmd_byte));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("frame byte %0d: last %0b, want %0b",
                                            frames_seen, rsp_last, want.last));
            end
            frames_seen++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_tracked_block_drive_command NOT OK");
      $finish;
   end

   function automatic logic [15:0] pick_coord(input int lo_edge, input int hi_edge);
      case ($urandom_range(0, 4))
         0: return 16'(lo_edge + $urandom_range(0, 2) - 1);
         1: return 16'(hi_edge + $urandom_range(0, 2) - 1);
         2: return 16'($urandom_range(0, 1023));
         3: return 16'($urandom);
         default: return 16'($urandom_range(0, 400));
      endcase
   endfunction

   function automatic logic [15:0] pick_extent();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'($urandom_range(0, 150));
         2: return 16'($urandom_range(0, 400));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_stray(input int n);
      int i;
      for (i = 0; i < n; i++)
         reply_bytes_to_send.push_back({8'($urandom), 1'b0});
      queued_items += n;
   endtask

   // builds one reply; cut < 0 sends it whole, else only the first cut bytes
   task automatic queue_packet(input int len, input logic [15:0] x, y, w, h,
                               input bit zero_fill, input bit sum_ok, input int cut);
      logic [7:0]  pkt[$];
      logic [7:0]  b;
      logic [15:0] sum;
      int p;
      int n;
      sum = '0;
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
      pkt.push_back(8'(len));
      pkt.push_back(8'd0);
      pkt.push_back(8'd0);
      for (p = POS_PAYLOAD; p < POS_PAYLOAD + len; p++) begin
         case (p)
            POS_PAYLOAD + 2: b = x[7:0];
            POS_PAYLOAD + 3: b = x[15:8];
            POS_PAYLOAD + 4: b = y[7:0];
            POS_PAYLOAD + 5: b = y[15:8];
            POS_PAYLOAD + 6: b = w[7:0];
            POS_PAYLOAD + 7: b = w[15:8];
            POS_PAYLOAD + 8: b = h[7:0];
            POS_PAYLOAD + 9: b = h[15:8];
            default: b = 8'($urandom);
         endcase
         if (zero_fill)
            b = 8'd0;
         sum = sum + b;
         pkt.push_back(b);
      end
      if (!sum_ok)
         sum = sum ^ 16'($urandom_range(1, 65535));
      pkt[POS_SUM_LO] = sum[7:0];
      pkt[POS_SUM_HI] = sum[15:8];
      n = (cut < 0 || cut > pkt.size()) ? pkt.size() : cut;
      for (p = 0; p < n; p++)
         reply_bytes_to_send.push_back({pkt[p], p == 0});
      queued_items += n;
   endtask

   task automatic queue_random_packet();
      int kind;
      int r;
      int len;
      int target;
      logic [15:0] x, y, w, h;
      kind = $urandom_range(0, 99);
      r = $urandom_range(0, 99);
      if (r < 40)
         len = 14;
      else if (r < 55)
         len = 10;
      else if (r < 80)
         len = $urandom_range(0, 16);
      else if (r < 90)
         len = $urandom_range(0, 5);
      else
         len = $urandom_range(17, 30);
      x = pick_coord(x_left, x_right);
      y = pick_coord(y_low, y_high);
      if ($urandom_range(0, 2) == 0) begin
         // aim the area at one of the thresholds
         target = $urandom_range(0, 1) ? int'(close_lim) : int'(stop_lim);
         w = 16'($urandom_range(1, 255));
         h = 16'(target / int'(w) + int'($urandom_range(0, 2)) - 1);
      end else begin
         w = pick_extent();
         h = pick_extent();
      end
      if (kind < 8)
         queue_stray($urandom_range(1, 3));
      else if (kind < 18)
         queue_packet(len, x, y, w, h, 1'b0, 1'b0, -1);
      else if (kind < 28)
         queue_packet(len, x, y, w, h, 1'b0, 1'b1, $urandom_range(1, POS_SUM_HI + len));
      else if (kind < 33)
         queue_packet(len, x, y, w, h, 1'b1, 1'b1, -1);
      else
         queue_packet(len, x, y, w, h, 1'b0, 1'b1, -1);
   endtask

   task automatic run_random(input int n);
      int start;
      start = queued_items;
      while (queued_items - start < n)
         queue_random_packet();
      // close the phase on a clean packet
      queue_packet(14, pick_coord(x_left, x_right), pick_coord(y_low, y_high),
                   pick_extent(), pick_extent(), 1'b0, 1'b1, -1);
   endtask

   task automatic let_block_settle();
      while (taken_items < queued_items || frame_bytes_due.size() > 0)
         @(posedge clock);
      // a bad sum gives no frame, so allow for the check still in progress
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(input csr_index_type idx, input logic [CSR_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_X_LEFT:    x_left = val[EDGE_W-1:0];
         CSR_X_RIGHT:   x_right = val[EDGE_W-1:0];
         CSR_Y_LOW:     y_low = val[EDGE_W-1:0];
         CSR_Y_HIGH:    y_high = val[EDGE_W-1:0];
         CSR_CLOSE:     close_lim = val[AREA_CW-1:0];
         CSR_STOP:      stop_lim = val[AREA_CW-1:0];
         CSR_MAX_SPEED: top_speed = val[SPEED_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input int xl, xr, yl, yh, close_v, stop_v, speed_v);
      let_block_settle();
      write_setting(CSR_X_LEFT, CSR_W'(xl));
      write_setting(CSR_X_RIGHT, CSR_W'(xr));
      write_setting(CSR_Y_LOW, CSR_W'(yl));
      write_setting(CSR_Y_HIGH, CSR_W'(yh));
      write_setting(CSR_CLOSE, CSR_W'(close_v));
      write_setting(CSR_STOP, CSR_W'(stop_v));
      write_setting(CSR_MAX_SPEED, CSR_W'(speed_v));
   endtask

   initial begin : stimulus
      int start;
      int waited;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at the reset thresholds
      queue_stray(1);
      queue_packet(0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, -1);
      queue_packet(0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, -1);
      queue_packet(14, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 2);
      queue_packet(8, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b1, -1);
      run_random(PHASE_ITEMS);

      apply_settings(0, 0, 0, 0, 1, 0, 0);
      run_random(PHASE_ITEMS);

      apply_settings(1023, 1023, 1023, 1023, 20'hFFFFF, 20'hFFFFF, 127);
      run_random(PHASE_ITEMS);

      // a stretch with no idling, speed saturating
      idle_on = 1'b0;
      apply_settings(138, 178, 89, 119, 1, 20'hFFFFF, 127);
      queue_packet(14, 16'd150, 16'd100, 16'd400, 16'd400, 1'b0, 1'b1, -1);
      run_random(PHASE_ITEMS);
      idle_on = 1'b1;

      // zero close area, sections overlapping and an empty y band
      apply_settings(178, 138, 119, 89, 0, $urandom_range(0, 200000), $urandom_range(0, 127));
      queue_packet(10, 16'd150, 16'd100, 16'd0, 16'd0, 1'b0, 1'b1, -1);
      run_random(PHASE_ITEMS);

      apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), $urandom_range(1, 100000),
                     $urandom_range(0, 200000), $urandom_range(0, 127));
      run_random(PHASE_ITEMS);

      apply_settings($urandom_range(100, 200), $urandom_range(150, 300), $urandom_range(50, 120),
                     $urandom_range(90, 200), $urandom_range(1, 20000),
                     $urandom_range(10000, 60000), $urandom_range(0, 127));
      idle_on = 1'b0;
      start = queued_items;
      while (queued_items - start < PHASE_ITEMS) begin
         queue_random_packet();
         while (reply_bytes_to_send.size() > 0)
            @(posedge clock);
      end

      while (taken_items < queued_items)
         @(posedge clock);
      waited = 0;
      while (frame_bytes_due.size() > 0 && waited < END_WAIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (frame_bytes_due.size() != 0)
         report_mismatch($sformatf("%0d frame bytes never came", frame_bytes_due.size()));
      if (mismatches == 0)
         $display("tb_tracked_block_drive_command OK");
      else
         $display("tb_tracked_block_drive_command NOT OK");
      $finish;
   end

endmodule
